@@ src/md5_pkg.sv @@
`timescale 1ns / 1ps

package md5_pkg;

  localparam int WORD_W    = 32;
  localparam int MSG_WORDS = 16;

  typedef logic [3:0][31:0] word4_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_PAD,
    ST_FETCH,
    ST_PREP,
    ST_ROUND,
    ST_FOLD,
    ST_OUT
  } md5_state_e;

  typedef struct packed {
    logic       init;      // load working regs from chain, prefetch round 0 K+M
    logic       step;      // run one round
    logic [5:0] round;     // round being run
    logic [5:0] kw_round;  // round whose K+M is prefetched this cycle
  } rnd_ctrl_t;

  localparam word4_t CHAIN_INIT = {32'h10325476, 32'h98badcfe, 32'hefcdab89, 32'h67452301};
  localparam logic [31:0] PAD_WORD = 32'h0000_0080;
  localparam logic [3:0] LEN_LO_SLOT = 4'd14;
  localparam logic [3:0] LAST_SLOT = 4'd15;
  localparam logic [5:0] LAST_ROUND = 6'd63;
  localparam logic [2:0] FULL_COUNT = 3'd4;

  function automatic logic [31:0] k_rom(input logic [5:0] i);
    logic [31:0] k;
    case (i)
      6'd0:  k = 32'hd76aa478;  6'd1:  k = 32'he8c7b756;
      6'd2:  k = 32'h242070db;  6'd3:  k = 32'hc1bdceee;
      6'd4:  k = 32'hf57c0faf;  6'd5:  k = 32'h4787c62a;
      6'd6:  k = 32'ha8304613;  6'd7:  k = 32'hfd469501;
      6'd8:  k = 32'h698098d8;  6'd9:  k = 32'h8b44f7af;
      6'd10: k = 32'hffff5bb1;  6'd11: k = 32'h895cd7be;
      6'd12: k = 32'h6b901122;  6'd13: k = 32'hfd987193;
      6'd14: k = 32'ha679438e;  6'd15: k = 32'h49b40821;
      6'd16: k = 32'hf61e2562;  6'd17: k = 32'hc040b340;
      6'd18: k = 32'h265e5a51;  6'd19: k = 32'he9b6c7aa;
      6'd20: k = 32'hd62f105d;  6'd21: k = 32'h02441453;
      6'd22: k = 32'hd8a1e681;  6'd23: k = 32'he7d3fbc8;
      6'd24: k = 32'h21e1cde6;  6'd25: k = 32'hc33707d6;
      6'd26: k = 32'hf4d50d87;  6'd27: k = 32'h455a14ed;
      6'd28: k = 32'ha9e3e905;  6'd29: k = 32'hfcefa3f8;
      6'd30: k = 32'h676f02d9;  6'd31: k = 32'h8d2a4c8a;
      6'd32: k = 32'hfffa3942;  6'd33: k = 32'h8771f681;
      6'd34: k = 32'h6d9d6122;  6'd35: k = 32'hfde5380c;
      6'd36: k = 32'ha4beea44;  6'd37: k = 32'h4bdecfa9;
      6'd38: k = 32'hf6bb4b60;  6'd39: k = 32'hbebfbc70;
      6'd40: k = 32'h289b7ec6;  6'd41: k = 32'heaa127fa;
      6'd42: k = 32'hd4ef3085;  6'd43: k = 32'h04881d05;
      6'd44: k = 32'hd9d4d039;  6'd45: k = 32'he6db99e5;
      6'd46: k = 32'h1fa27cf8;  6'd47: k = 32'hc4ac5665;
      6'd48: k = 32'hf4292244;  6'd49: k = 32'h432aff97;
      6'd50: k = 32'hab9423a7;  6'd51: k = 32'hfc93a039;
      6'd52: k = 32'h655b59c3;  6'd53: k = 32'h8f0ccc92;
      6'd54: k = 32'hffeff47d;  6'd55: k = 32'h85845dd1;
      6'd56: k = 32'h6fa87e4f;  6'd57: k = 32'hfe2ce6e0;
      6'd58: k = 32'ha3014314;  6'd59: k = 32'h4e0811a1;
      6'd60: k = 32'hf7537e82;  6'd61: k = 32'hbd3af235;
      6'd62: k = 32'h2ad7d2bb;  6'd63: k = 32'heb86d391;
      default: k = 32'h0;
    endcase
    return k;
  endfunction

  function automatic logic [4:0] shift_amt(input logic [5:0] i);
    logic [4:0] s;
    case ({i[5:4], i[1:0]})
      4'h0: s = 5'd7;   4'h1: s = 5'd12;  4'h2: s = 5'd17;  4'h3: s = 5'd22;
      4'h4: s = 5'd5;   4'h5: s = 5'd9;   4'h6: s = 5'd14;  4'h7: s = 5'd20;
      4'h8: s = 5'd4;   4'h9: s = 5'd11;  4'ha: s = 5'd16;  4'hb: s = 5'd23;
      4'hc: s = 5'd6;   4'hd: s = 5'd10;  4'he: s = 5'd15;  4'hf: s = 5'd21;
      default: s = 5'd0;
    endcase
    return s;
  endfunction

  // Message word used by round i; only i mod 16 matters for each phase.
  function automatic logic [3:0] msg_index(input logic [5:0] i);
    logic [3:0] j;
    logic [3:0] g;
    j = i[3:0];
    case (i[5:4])
      2'd0:    g = j;
      2'd1:    g = (j << 2) + j + 4'd1;
      2'd2:    g = (j << 1) + j + 4'd5;
      default: g = (j << 3) - j;
    endcase
    return g;
  endfunction

  function automatic logic [31:0] round_f(input logic [1:0] phase, input logic [31:0] b,
                                          input logic [31:0] c, input logic [31:0] d);
    logic [31:0] f;
    case (phase)
      2'd0:    f = (b & c) | (~b & d);
      2'd1:    f = (b & d) | (c & ~d);
      2'd2:    f = b ^ c ^ d;
      default: f = c ^ (b | ~d);
    endcase
    return f;
  endfunction

  function automatic logic [31:0] rotl32(input logic [31:0] x, input logic [4:0] s);
    logic [63:0] w;
    w = {x, x} << s;
    return w[63:32];
  endfunction

endpackage

@@ src/md5_msg_buf.sv @@
`timescale 1ns / 1ps

// Generic RAM: one write port, one read port with registered read data.
module md5_msg_buf #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 16
) (
  input  logic                     clk_i,
  input  logic                     wr_en_i,
  input  logic [$clog2(DEPTH)-1:0] wr_addr_i,
  input  logic [WIDTH-1:0]         wr_data_i,
  input  logic [$clog2(DEPTH)-1:0] rd_addr_i,
  output logic [WIDTH-1:0]         rd_data_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rd_data_q;

  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem_q[wr_addr_i] <= wr_data_i;
    end
    rd_data_q <= mem_q[rd_addr_i];
  end

  assign rd_data_o = rd_data_q;

endmodule

@@ src/md5_round.sv @@
`timescale 1ns / 1ps

// Shared round unit: one MD5 round per step. K+M for the next round is
// prefetched into kw_q so a round is F, one add pair, a rotate and an add.
module md5_round
  import md5_pkg::*;
(
  input  logic        clk_i,
  input  rnd_ctrl_t   ctrl_i,
  input  word4_t      chain_i,
  input  logic [31:0] msg_word_i,
  output word4_t      work_o
);

  logic [31:0] a_q, b_q, c_q, d_q;
  logic [31:0] a_d, b_d, c_d, d_d;
  logic [31:0] kw_q, kw_d;
  logic [31:0] f_val, sum;

  always_comb begin
    f_val = round_f(ctrl_i.round[5:4], b_q, c_q, d_q);
    sum   = a_q + f_val + kw_q;
    kw_d  = k_rom(ctrl_i.kw_round) + msg_word_i;
    a_d   = a_q;
    b_d   = b_q;
    c_d   = c_q;
    d_d   = d_q;
    if (ctrl_i.init) begin
      a_d = chain_i[0];
      b_d = chain_i[1];
      c_d = chain_i[2];
      d_d = chain_i[3];
    end else if (ctrl_i.step) begin
      a_d = d_q;
      d_d = c_q;
      c_d = b_q;
      b_d = b_q + rotl32(sum, shift_amt(ctrl_i.round));
    end
  end

  always_ff @(posedge clk_i) begin
    a_q  <= a_d;
    b_q  <= b_d;
    c_q  <= c_d;
    d_q  <= d_d;
    kw_q <= kw_d;
  end

  assign work_o = {d_q, c_q, b_q, a_q};

endmodule

@@ src/md5_hash_engine_top.sv @@
`timescale 1ns / 1ps

// Channel  | valid / stall           | payload
// ---------+-------------------------+--------------------------------------
// in       | in_valid_i / in_stall_o | data_word_i, byte_count_i, last_i
// out      | out_valid_o/ out_stall_i| digest_word_o, word_index_o, last_word_o
//
// A word that is neither last nor fills the block leaves the engine idle, ready for the
// next word. The 16th word of a block starts a compression (message read, load, 64
// rounds through the shared round unit, chain fold). A final word adds the padding
// words and one or two compressions, then four digest transactions.
// in_stall_o is high whenever the engine is not idle. Reset is asynchronous
// and returns the chain to its initial value; no clearing pass is needed.
module md5_hash_engine_top
  import md5_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic [31:0] data_word_i,
  input  logic [2:0]  byte_count_i,
  input  logic        last_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [31:0] digest_word_o,
  output logic [1:0]  word_index_o,
  output logic        last_word_o
);

  md5_state_e  state_q, state_d;
  logic [5:0]  round_q, round_d;
  logic [3:0]  fill_q, fill_d;
  logic [63:0] bits_q, bits_d;
  logic        pend80_q, pend80_d;
  logic        len_ok_q, len_ok_d;
  logic        pad_mode_q, pad_mode_d;
  logic        final_q, final_d;
  logic [1:0]  out_idx_q, out_idx_d;
  word4_t      chain_q, chain_d;

  logic        in_xfer, out_xfer;
  logic [2:0]  count_eff;
  logic [31:0] tail_word;
  logic        wr_en;
  logic [31:0] wr_data;
  logic [5:0]  rd_round;
  logic [3:0]  rd_addr;
  logic [31:0] rd_data;
  rnd_ctrl_t   rnd_ctrl;
  word4_t      work;

  assign in_stall_o  = (state_q != ST_IDLE);
  assign in_xfer     = in_valid_i && !in_stall_o;
  assign out_valid_o = (state_q == ST_OUT);
  assign out_xfer    = out_valid_o && !out_stall_i;

  assign digest_word_o = chain_q[out_idx_q];
  assign word_index_o  = out_idx_q;
  assign last_word_o   = (out_idx_q == 2'd3);

  // Final partial word: keep the valid bytes, 0x80 right after them.
  always_comb begin
    count_eff = (!last_i || byte_count_i > FULL_COUNT) ? FULL_COUNT : byte_count_i;
    case (count_eff)
      3'd0:    tail_word = PAD_WORD;
      3'd1:    tail_word = {16'h0, PAD_WORD[7:0], data_word_i[7:0]};
      3'd2:    tail_word = {8'h0, PAD_WORD[7:0], data_word_i[15:0]};
      3'd3:    tail_word = {PAD_WORD[7:0], data_word_i[23:0]};
      default: tail_word = data_word_i;
    endcase
  end

  always_comb begin
    state_d    = state_q;
    round_d    = round_q;
    fill_d     = fill_q;
    bits_d     = bits_q;
    pend80_d   = pend80_q;
    len_ok_d   = len_ok_q;
    pad_mode_d = pad_mode_q;
    final_d    = final_q;
    out_idx_d  = out_idx_q;
    chain_d    = chain_q;
    wr_en      = 1'b0;
    wr_data    = tail_word;
    // message read runs one round ahead of the K+M prefetch
    rd_round   = round_q + 6'd2;
    rnd_ctrl   = '{init: 1'b0, step: 1'b0, round: round_q, kw_round: round_q + 6'd1};

    case (state_q)
      ST_IDLE: begin
        if (in_xfer) begin
          wr_en  = 1'b1;
          fill_d = fill_q + 4'd1;
          bits_d = bits_q + {58'd0, count_eff, 3'd0};
          if (last_i) begin
            pad_mode_d = 1'b1;
            final_d    = 1'b0;
            pend80_d   = (count_eff == FULL_COUNT);
            len_ok_d   = (fill_q < LEN_LO_SLOT);
          end
          if (fill_q == LAST_SLOT) begin
            state_d = ST_FETCH;
          end else if (last_i) begin
            state_d = ST_PAD;
          end
        end
      end

      ST_PAD: begin
        wr_en  = 1'b1;
        fill_d = fill_q + 4'd1;
        if (pend80_q) begin
          wr_data  = PAD_WORD;
          pend80_d = 1'b0;
          len_ok_d = (fill_q < LEN_LO_SLOT);
        end else if (len_ok_q && fill_q == LEN_LO_SLOT) begin
          wr_data = bits_q[31:0];
        end else if (len_ok_q && fill_q == LAST_SLOT) begin
          wr_data = bits_q[63:32];
          final_d = 1'b1;
        end else begin
          wr_data = 32'h0;
        end
        if (fill_q == LAST_SLOT) begin
          state_d = ST_FETCH;
        end
      end

      ST_FETCH: begin
        rd_round = 6'd0;
        state_d  = ST_PREP;
      end

      ST_PREP: begin
        rnd_ctrl.init     = 1'b1;
        rnd_ctrl.kw_round = 6'd0;
        rd_round          = 6'd1;
        round_d           = 6'd0;
        state_d           = ST_ROUND;
      end

      ST_ROUND: begin
        rnd_ctrl.step = 1'b1;
        round_d       = round_q + 6'd1;
        if (round_q == LAST_ROUND) begin
          state_d = ST_FOLD;
        end
      end

      ST_FOLD: begin
        for (int k = 0; k < 4; k++) begin
          chain_d[k] = chain_q[k] + work[k];
        end
        if (final_q) begin
          state_d = ST_OUT;
        end else if (pad_mode_q) begin
          // block wrapped during padding: length fits in the next one
          len_ok_d = 1'b1;
          state_d  = ST_PAD;
        end else begin
          state_d = ST_IDLE;
        end
      end

      ST_OUT: begin
        if (out_xfer) begin
          out_idx_d = out_idx_q + 2'd1;
          if (out_idx_q == 2'd3) begin
            chain_d    = CHAIN_INIT;
            bits_d     = 64'd0;
            fill_d     = 4'd0;
            pad_mode_d = 1'b0;
            final_d    = 1'b0;
            state_d    = ST_IDLE;
          end
        end
      end

      default: state_d = ST_IDLE;
    endcase
  end

  assign rd_addr = msg_index(rd_round);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= ST_IDLE;
      round_q    <= 6'd0;
      fill_q     <= 4'd0;
      bits_q     <= 64'd0;
      pend80_q   <= 1'b0;
      len_ok_q   <= 1'b0;
      pad_mode_q <= 1'b0;
      final_q    <= 1'b0;
      out_idx_q  <= 2'd0;
      chain_q    <= CHAIN_INIT;
    end else begin
      state_q    <= state_d;
      round_q    <= round_d;
      fill_q     <= fill_d;
      bits_q     <= bits_d;
      pend80_q   <= pend80_d;
      len_ok_q   <= len_ok_d;
      pad_mode_q <= pad_mode_d;
      final_q    <= final_d;
      out_idx_q  <= out_idx_d;
      chain_q    <= chain_d;
    end
  end

  md5_msg_buf #(
    .WIDTH (WORD_W),
    .DEPTH (MSG_WORDS)
  ) u_msg_buf (
    .clk_i     (clk_i),
    .wr_en_i   (wr_en),
    .wr_addr_i (fill_q),
    .wr_data_i (wr_data),
    .rd_addr_i (rd_addr),
    .rd_data_o (rd_data)
  );

  md5_round u_round (
    .clk_i      (clk_i),
    .ctrl_i     (rnd_ctrl),
    .chain_i    (chain_q),
    .msg_word_i (rd_data),
    .work_o     (work)
  );

  a_round_end: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_ROUND && round_q == LAST_ROUND) |=> state_q == ST_FOLD)
    else $error("round sequence did not end in fold");

  a_block_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ((in_xfer || state_q == ST_PAD) && fill_q == LAST_SLOT) |=> state_q == ST_FETCH)
    else $error("full block not compressed");

  a_out_aligned: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (fill_q == 4'd0 && !pend80_q))
    else $error("digest emitted with unaligned message block");

  a_digest_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_xfer && last_word_o) |=> (state_q == ST_IDLE && bits_q == 64'd0 &&
                                   chain_q == CHAIN_INIT))
    else $error("engine not restarted after digest");

endmodule
